@@ rtl/core/gdad_pkg.sv @@
// ----------------------------------------------------------------------------
// gdad_pkg: shared types and constants for the Gregorian date adder
// Widths, month tables, leap test, sequencer states and the control
// and status bundles passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package gdad_pkg;

  // Field widths
  localparam int OFFSET_WIDTH = 16;
  localparam int YEAR_W       = 14;
  localparam int MONTH_W      = 4;
  localparam int DAY_W        = 5;

  // Shared adder width: holds day plus offset, and the biased start year
  localparam int ALU_W = (OFFSET_WIDTH + 1 > 16) ? OFFSET_WIDTH + 1 : 16;

  // Biased year register: wide enough for the start span plus the offset span
  localparam int YB_SPAN = (OFFSET_WIDTH - 9 > 15) ? OFFSET_WIDTH - 9 : 15;
  localparam int YB_W    = YB_SPAN + 2;

  // Reduction register for the start year (biased year < 2^15)
  localparam int RED_W = 15;
  // Year position inside the 400-year cycle
  localparam int R4_W  = 9;

  localparam int YEAR_BIAS  = 400;
  localparam int YEAR_CYCLE = 400;
  localparam int YB_LO      = YEAR_BIAS + 1;
  localparam int YB_HI      = YEAR_BIAS + 9999;

  // Reduction steps: subtract 400 << k for k = MOD_TOP down to 0
  localparam int K_W = 3;
  localparam logic [K_W-1:0] MOD_TOP = K_W'(5);

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DEC_LEN   = DAY_W'(31);

  // Month lengths, padded to the full month code range
  localparam logic [DAY_W-1:0] LEN_LEAP [16] = '{
    5'd0, 5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };
  localparam logic [DAY_W-1:0] LEN_COMMON [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // Sequencer to datapath
  typedef struct packed {
    logic           load;
    logic           mod_step;
    logic [K_W-1:0] k;
    logic           walk;
    logic           out_load;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic walk_done;
    logic out_free;
  } status_t;

  // Leap test on the year position inside the 400-year cycle
  function automatic logic is_leap(logic [R4_W-1:0] r);
    return (r[1:0] == 2'b00) && (r != R4_W'(100)) && (r != R4_W'(200)) &&
           (r != R4_W'(300));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(logic leap, logic [MONTH_W-1:0] m);
    return leap ? LEN_LEAP[m] : LEN_COMMON[m];
  endfunction

endpackage

@@ rtl/core/gdad_alu.sv @@
// ----------------------------------------------------------------------------
// gdad_alu: shared add/subtract unit
// Serves the offset load, the mod-400 reduction and every month step.
// ----------------------------------------------------------------------------
module gdad_alu (
  input  logic signed [gdad_pkg::ALU_W-1:0] a_i,
  input  logic signed [gdad_pkg::ALU_W-1:0] b_i,
  input  gdad_pkg::alu_op_e                 op_i,
  output logic signed [gdad_pkg::ALU_W-1:0] sum_o
);
  import gdad_pkg::*;

  // Add or subtract the operand
  always_comb begin
    unique case (op_i)
      ALU_ADD: sum_o = a_i + b_i;
      ALU_SUB: sum_o = a_i - b_i;
      default: sum_o = a_i + b_i;
    endcase
  end

endmodule

@@ rtl/core/gdad_ctrl.sv @@
// ----------------------------------------------------------------------------
// gdad_ctrl: sequencer for the date adder
// Steps load, mod-400 reduction, month walk and result hand-off.
// ----------------------------------------------------------------------------
module gdad_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  gdad_pkg::status_t status_i,
  output gdad_pkg::ctrl_t   ctrl_o,
  output logic              busy_o
);
  import gdad_pkg::*;

  state_e         state_q, state_d;
  logic [K_W-1:0] k_q, k_d;

  // Hold state and reduction step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MOD;
          k_d     = MOD_TOP;
        end
      end
      ST_MOD: begin
        if (k_q == '0) begin
          state_d = ST_WALK;
        end else begin
          k_d = k_q - K_W'(1);
        end
      end
      ST_WALK: begin
        if (status_i.walk_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.k        = k_q;
    busy_o          = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o      = 1'b0;
        ctrl_o.load = in_valid_i;
      end
      ST_MOD:  ctrl_o.mod_step = 1'b1;
      ST_WALK: ctrl_o.walk     = 1'b1;
      ST_DONE: ctrl_o.out_load = status_i.out_free;
      default: busy_o          = 1'b1;
    endcase
  end

endmodule

@@ rtl/core/gregorian_date_add_days_core.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_add_days_core: add a signed day count to a Gregorian date
// Walks month by month from the start date using one shared adder.
//
//   channel | handshake               | payload
//   --------+-------------------------+----------------------------------------
//   in      | in_valid_i / in_stall_o | start_year, start_month, start_day,
//           |                         | day_offset
//   out     | out_valid_o/out_stall_i | result_year, result_month, result_day,
//           |                         | out_of_range
//
// An item passes through one load, six mod-400 steps on the start year, one
// adder pass per month boundary crossed plus a final check, and one output
// load. The month walk runs on the single shared adder; a 16-bit offset
// crosses up to about 1080 months.
// in_stall_o is high from acceptance until the result enters the output
// register. The output register holds a beat while out_stall_i is high; the
// next item may be accepted while it waits. Reset clears the sequencer and
// the output valid.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_core (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic [gdad_pkg::YEAR_W-1:0]              start_year_i,
  input  logic [gdad_pkg::MONTH_W-1:0]             start_month_i,
  input  logic [gdad_pkg::DAY_W-1:0]               start_day_i,
  input  logic signed [gdad_pkg::OFFSET_WIDTH-1:0] day_offset_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic [gdad_pkg::YEAR_W-1:0]              result_year_o,
  output logic [gdad_pkg::MONTH_W-1:0]             result_month_o,
  output logic [gdad_pkg::DAY_W-1:0]               result_day_o,
  output logic                                     out_of_range_o
);
  import gdad_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    busy;

  logic signed [ALU_W-1:0] alu_a, alu_b, alu_sum;
  alu_op_e                 alu_op;

  logic signed [YB_W-1:0]  yb_q, yb_d;
  logic [RED_W-1:0]        r_q, r_d;
  logic signed [ALU_W-1:0] t_q, t_d;
  logic [MONTH_W-1:0]      m_q, m_d;

  logic                    out_valid_q, out_valid_d;
  logic [YEAR_W-1:0]       res_year_q, res_year_d;
  logic [MONTH_W-1:0]      res_month_q, res_month_d;
  logic [DAY_W-1:0]        res_day_q, res_day_d;
  logic                    res_oor_q, res_oor_d;

  logic [R4_W-1:0]  r400;
  logic             leap;
  logic [DAY_W-1:0] len_cur, len_prev;
  logic             t_neg, sum_neg, in_range;

  gdad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  gdad_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .sum_o (alu_sum)
  );

  // Month lengths around the current position
  assign r400     = r_q[R4_W-1:0];
  assign leap     = is_leap(r400);
  assign len_cur  = month_len(leap, m_q);
  assign len_prev = (m_q == MONTH_JAN) ? DEC_LEN : month_len(leap, m_q - MONTH_W'(1));
  assign t_neg    = t_q[ALU_W-1];
  assign sum_neg  = alu_sum[ALU_W-1];
  assign in_range = (yb_q >= YB_W'(YB_LO)) && (yb_q <= YB_W'(YB_HI));

  assign status.walk_done = !t_neg && sum_neg;
  assign status.out_free  = !out_valid_q || !out_stall_i;

  // Select adder operands
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = ALU_ADD;
    if (ctrl.load) begin
      alu_a  = ALU_W'(day_offset_i);
      alu_b  = ALU_W'(start_day_i) - ALU_W'(1);
    end else if (ctrl.mod_step) begin
      alu_a  = ALU_W'(r_q);
      alu_b  = ALU_W'(YEAR_CYCLE) << ctrl.k;
      alu_op = ALU_SUB;
    end else if (ctrl.walk) begin
      alu_a = t_q;
      if (t_neg) begin
        alu_b = ALU_W'(len_prev);
      end else begin
        alu_b  = ALU_W'(len_cur);
        alu_op = ALU_SUB;
      end
    end
  end

  // Load, reduce and walk
  always_comb begin
    yb_d = yb_q;
    r_d  = r_q;
    t_d  = t_q;
    m_d  = m_q;
    if (ctrl.load) begin
      t_d = alu_sum;
      // Normalize month into 1..12 with a biased year
      priority if (start_month_i == '0) begin
        yb_d = YB_W'(start_year_i) + YB_W'(YEAR_BIAS) - YB_W'(1);
        m_d  = MONTH_DEC;
      end else if (start_month_i > MONTH_DEC) begin
        yb_d = YB_W'(start_year_i) + YB_W'(YEAR_BIAS) + YB_W'(1);
        m_d  = start_month_i - MONTH_DEC;
      end else begin
        yb_d = YB_W'(start_year_i) + YB_W'(YEAR_BIAS);
        m_d  = start_month_i;
      end
      r_d = RED_W'(yb_d);
    end else if (ctrl.mod_step) begin
      if (!sum_neg) begin
        r_d = RED_W'(alu_sum);
      end
    end else if (ctrl.walk) begin
      if (t_neg) begin
        // Step back one month
        t_d = alu_sum;
        if (m_q == MONTH_JAN) begin
          m_d  = MONTH_DEC;
          yb_d = yb_q - YB_W'(1);
          r_d  = (r400 == '0) ? RED_W'(YEAR_CYCLE - 1) : RED_W'(r400 - R4_W'(1));
        end else begin
          m_d = m_q - MONTH_W'(1);
        end
      end else if (!sum_neg) begin
        // Step forward one month
        t_d = alu_sum;
        if (m_q == MONTH_DEC) begin
          m_d  = MONTH_JAN;
          yb_d = yb_q + YB_W'(1);
          r_d  = (r400 == R4_W'(YEAR_CYCLE - 1)) ? '0 : RED_W'(r400 + R4_W'(1));
        end else begin
          m_d = m_q + MONTH_W'(1);
        end
      end
    end
  end

  // Hold the working registers
  always_ff @(posedge clk_i) begin
    yb_q <= yb_d;
    r_q  <= r_d;
    t_q  <= t_d;
    m_q  <= m_d;
  end

  // Build the result beat
  always_comb begin
    out_valid_d = out_valid_q;
    res_year_d  = res_year_q;
    res_month_d = res_month_q;
    res_day_d   = res_day_q;
    res_oor_d   = res_oor_q;
    if (ctrl.out_load) begin
      out_valid_d = 1'b1;
      res_oor_d   = !in_range;
      if (in_range) begin
        res_year_d  = YEAR_W'(yb_q - YB_W'(YEAR_BIAS));
        res_month_d = m_q;
        res_day_d   = DAY_W'(t_q) + DAY_W'(1);
      end else begin
        res_year_d  = '0;
        res_month_d = '0;
        res_day_d   = '0;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_year_q  <= res_year_d;
    res_month_q <= res_month_d;
    res_day_q   <= res_day_d;
    res_oor_q   <= res_oor_d;
  end

  assign in_stall_o     = busy;
  assign out_valid_o    = out_valid_q;
  assign result_year_o  = res_year_q;
  assign result_month_o = res_month_q;
  assign result_day_o   = res_day_q;
  assign out_of_range_o = res_oor_q;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after accepting an item");

  a_month_normalized: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (m_q >= MONTH_JAN) && (m_q <= MONTH_DEC))
    else $error("working month left 1..12");

  a_cycle_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.walk |-> (r_q < RED_W'(YEAR_CYCLE)))
    else $error("year cycle position not reduced below 400");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |->
      (result_year_o == '0) && (result_month_o == '0) && (result_day_o == '0))
    else $error("out-of-range beat carries a date");

  a_valid_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_of_range_o |->
      (result_year_o != '0) && (result_month_o != '0) &&
      (result_month_o <= MONTH_DEC) && (result_day_o != '0))
    else $error("in-range beat carries a malformed date");

endmodule
